FILE: rtl/ilid_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ilid_pkg: shared types and constants for the indexed list
// Capacity, index widths, action and status codes, payload structs.
// ----------------------------------------------------------------------------
package ilid_pkg;

	localparam int CAPACITY = 64;
	localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int POS_W    = 7;
	localparam int LEN_W    = 7;
	localparam int VAL_W    = 32;
	localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

	localparam logic [2:0] ACT_GET    = 3'd0;
	localparam logic [2:0] ACT_HEAD   = 3'd1;
	localparam logic [2:0] ACT_TAIL   = 3'd2;
	localparam logic [2:0] ACT_INDEX  = 3'd3;
	localparam logic [2:0] ACT_DELETE = 3'd4;

	localparam logic [1:0] ST_DONE    = 2'd0;
	localparam logic [1:0] ST_INVALID = 2'd1;
	localparam logic [1:0] ST_FULL    = 2'd2;

	typedef struct packed {
		logic [2:0]              action;
		logic [POS_W-1:0]        position;
		logic signed [VAL_W-1:0] value;
	} req_t;

	typedef struct packed {
		logic signed [VAL_W-1:0] read_value;
		logic [1:0]              status;
		logic [LEN_W-1:0]        length;
	} rsp_t;

	// broadcast to every cell of the chain
	typedef struct packed {
		logic             shift_up;
		logic             shift_down;
		logic [CMP_W-1:0] pos;
		logic [VAL_W-1:0] value;
	} cell_ctrl_t;

endpackage

FILE: rtl/ilid_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ilid_cell: one list entry
// Holds one value, takes its left or right neighbour or the new value on
// insert or delete and drives its value onto the read bus when it is selected.
// ----------------------------------------------------------------------------
module ilid_cell (
	input  logic                          clk,
	input  logic [ilid_pkg::IDX_W-1:0]    idx,
	input  ilid_pkg::cell_ctrl_t          ctrl,
	input  logic [ilid_pkg::VAL_W-1:0]    left,
	input  logic [ilid_pkg::VAL_W-1:0]    right,
	output logic [ilid_pkg::VAL_W-1:0]    data,
	output logic [ilid_pkg::VAL_W-1:0]    rd
);

	logic [ilid_pkg::VAL_W-1:0] data_q;
	logic [ilid_pkg::CMP_W-1:0] idx_w;
	logic                       above;
	logic                       here;

	assign idx_w = ilid_pkg::CMP_W'(idx);
	assign above = idx_w > ctrl.pos;
	assign here  = idx_w == ctrl.pos;

	always_ff @(posedge clk) begin
		if (ctrl.shift_up) begin
			if (above) begin
				data_q <= left;
			end else if (here) begin
				data_q <= ctrl.value;
			end
		end else if (ctrl.shift_down) begin
			if (above || here) begin
				data_q <= right;
			end
		end
	end

	assign data = data_q;
	assign rd   = here ? data_q : '0;

endmodule

FILE: rtl/indexed_list_insert_delete.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indexed_list_insert_delete: ordered list with insert and delete by position
// Top level: action decode, length counter, cell chain and result register.
// ----------------------------------------------------------------------------
// One operation is taken every clock cycle unless stalled; its result appears
// in the output register on the next edge; a new request is taken when that
// register is empty or being drained in the same cycle. Every insert or delete
// moves the entries from the position up at once, each cell taking its
// neighbour or the new value, so the rate is set by the length-position decode;
// a get reads through an OR tree over the cells. No clearing pass is needed
// after reset: only positions below the length are ever read.
module indexed_list_insert_delete (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	input  ilid_pkg::req_t    req,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	output ilid_pkg::rsp_t    rsp
);

	localparam int N = ilid_pkg::CAPACITY;

	logic [ilid_pkg::CNT_W-1:0] count_q;
	logic                       rsp_valid_q;
	ilid_pkg::rsp_t             rsp_q;

	ilid_pkg::cell_ctrl_t       ctrl;
	ilid_pkg::rsp_t             rsp_nxt;
	logic [ilid_pkg::VAL_W-1:0] cell_data [N];
	logic [ilid_pkg::VAL_W-1:0] cell_rd   [N];
	logic [ilid_pkg::VAL_W-1:0] rd_bus;
	logic [ilid_pkg::CMP_W-1:0] pos_w;
	logic [ilid_pkg::CMP_W-1:0] cnt_w;
	logic [ilid_pkg::CMP_W-1:0] ins_pos;
	logic                       fire;
	logic                       do_ins;
	logic                       do_del;
	logic                       is_add;

	assign fire      = req_valid && req_ready;
	assign req_ready = !rsp_valid_q || rsp_ready;
	assign pos_w     = ilid_pkg::CMP_W'(req.position);
	assign cnt_w     = ilid_pkg::CMP_W'(count_q);
	assign is_add    = (req.action == ilid_pkg::ACT_HEAD) || (req.action == ilid_pkg::ACT_TAIL)
		|| (req.action == ilid_pkg::ACT_INDEX);

	// selected cell drives, the rest give zero
	always_comb begin
		rd_bus = '0;
		for (int i = 0; i < N; i++) begin
			rd_bus = rd_bus | cell_rd[i];
		end
	end

	always_comb begin
		do_ins  = 1'b0;
		do_del  = 1'b0;
		ins_pos = pos_w;
		rsp_nxt.read_value = '0;
		rsp_nxt.status     = ilid_pkg::ST_DONE;
		unique case (req.action)
			ilid_pkg::ACT_GET: begin
				if (pos_w < cnt_w) begin
					rsp_nxt.read_value = rd_bus;
				end else begin
					rsp_nxt.read_value = '1;
					rsp_nxt.status     = ilid_pkg::ST_INVALID;
				end
			end
			ilid_pkg::ACT_HEAD, ilid_pkg::ACT_TAIL, ilid_pkg::ACT_INDEX: begin
				if (req.action == ilid_pkg::ACT_HEAD) begin
					ins_pos = '0;
				end else if (req.action == ilid_pkg::ACT_TAIL) begin
					ins_pos = cnt_w;
				end
				if (ins_pos > cnt_w) begin
					rsp_nxt.status = ilid_pkg::ST_INVALID;
				end else if (cnt_w >= ilid_pkg::CMP_W'(N)) begin
					rsp_nxt.status = ilid_pkg::ST_FULL;
				end else begin
					do_ins = 1'b1;
				end
			end
			ilid_pkg::ACT_DELETE: begin
				if (pos_w < cnt_w) begin
					do_del = 1'b1;
				end else begin
					rsp_nxt.status = ilid_pkg::ST_INVALID;
				end
			end
			default: begin
				rsp_nxt.status = ilid_pkg::ST_INVALID;
			end
		endcase
		rsp_nxt.length = do_ins ? ilid_pkg::LEN_W'(count_q + 1'b1)
			: do_del ? ilid_pkg::LEN_W'(count_q - 1'b1)
			: ilid_pkg::LEN_W'(count_q);
	end

	assign ctrl.shift_up   = fire && do_ins;
	assign ctrl.shift_down = fire && do_del;
	assign ctrl.pos        = ins_pos;
	assign ctrl.value      = req.value;

	for (genvar g = 0; g < N; g++) begin : g_cell
		ilid_cell u_cell (
			.clk   (clk),
			.idx   (ilid_pkg::IDX_W'(g)),
			.ctrl  (ctrl),
			.left  ((g == 0) ? cell_data[0] : cell_data[(g == 0) ? 0 : g - 1]),
			.right ((g == N - 1) ? cell_data[N - 1] : cell_data[(g == N - 1) ? g : g + 1]),
			.data  (cell_data[g]),
			.rd    (cell_rd[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (fire) begin
				if (do_ins) begin
					count_q <= count_q + 1'b1;
				end else if (do_del) begin
					count_q <= count_q - 1'b1;
				end
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			rsp_q <= rsp_nxt;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_w <= ilid_pkg::CMP_W'(N))
		else $error("list length beyond capacity");

	a_add_grows: assert property (@(posedge clk) disable iff (!arst_n)
		fire && is_add && rsp_nxt.status == ilid_pkg::ST_DONE
		|=> count_q == $past(count_q) + 1'b1)
		else $error("successful insert did not grow the list");

	a_full_only_at_cap: assert property (@(posedge clk) disable iff (!arst_n)
		fire && rsp_nxt.status == ilid_pkg::ST_FULL |-> cnt_w == ilid_pkg::CMP_W'(N))
		else $error("full status below capacity");

	a_refused_keeps_len: assert property (@(posedge clk) disable iff (!arst_n)
		fire && rsp_nxt.status != ilid_pkg::ST_DONE |=> $stable(count_q))
		else $error("refused operation changed the length");

	a_rsp_len_matches: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> rsp_q.length == ilid_pkg::LEN_W'(count_q))
		else $error("reported length differs from held length");

endmodule
